[rtl/core/timing_gradient_line_fit_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the timing gradient line fit block
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TIMING_GRADIENT_LINE_FIT_TOP_ASSERT_SVH
`define TIMING_GRADIENT_LINE_FIT_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define TGLF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TGLF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define TGLF_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define TGLF_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

[rtl/core/tglf_pkg.sv]
// ----------------------------------------------------------------------------
// Timing gradient line fit package
// Shared constants, field layout, command and status types.
// ----------------------------------------------------------------------------
`default_nettype none

package tglf_pkg;

   localparam int MAX_PIXELS = 2048;
   localparam int CNT_W      = $clog2(MAX_PIXELS + 1);

   localparam int REQ_DATA_W = 128;
   localparam int RSP_DATA_W = 64;

   // One quotient step per dividend bit plus twelve fraction steps.
   localparam int DIV_STEPS  = 140;
   localparam int DCNT_W     = $clog2(DIV_STEPS);

   typedef enum logic [3:0] {
      A_NONE,
      A_LOAD,
      A_PROJ1,
      A_PROJ2,
      A_TIME,
      A_WEIGHT,
      A_WX,
      A_WXT,
      A_WXX,
      A_CLEAR
   } accum_op_type;

   typedef enum logic [2:0] {
      STEP_WSXX,
      STEP_SXSX,
      STEP_WSXT,
      STEP_SXST,
      STEP_STSXX,
      STEP_SXSXT
   } fit_step_type;

   typedef enum logic {
      DIV_SLOPE,
      DIV_INTERCEPT
   } div_sel_type;

   typedef struct packed {
      accum_op_type op;
   } accum_cmd_type;

   typedef struct packed {
      logic last;
      logic room;
   } accum_stat_type;

   typedef struct packed {
      logic [47:0] weight_sum;
      logic [63:0] sum_x;
      logic [47:0] sum_t;
      logic [63:0] sum_xt;
      logic [63:0] sum_xx;
   } sums_type;

   typedef struct packed {
      logic         mul_start;
      logic         mul_store;
      fit_step_type step;
      logic         div_start;
      logic         div_store;
      div_sel_type  div_sel;
      logic         out_load;
   } solve_cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic degen;
   } solve_stat_type;

endpackage

`default_nettype wire

[rtl/core/tglf_ctrl.sv]
// ----------------------------------------------------------------------------
// Timing gradient line fit controller
// Sequences pixel accumulation, the fit products, the divisions and output.
// ----------------------------------------------------------------------------
`default_nettype none

module tglf_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   input  wire                     req_tlast,
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   output tglf_pkg::accum_cmd_type acmd,
   input  tglf_pkg::accum_stat_type astat,
   output tglf_pkg::solve_cmd_type scmd,
   input  tglf_pkg::solve_stat_type sstat
);
   import tglf_pkg::*;

   typedef enum logic [13:0] {
      S_IDLE   = 14'b00000000000001,
      S_PROJ1  = 14'b00000000000010,
      S_PROJ2  = 14'b00000000000100,
      S_TIME   = 14'b00000000001000,
      S_WEIGHT = 14'b00000000010000,
      S_WX     = 14'b00000000100000,
      S_WXT    = 14'b00000001000000,
      S_WXX    = 14'b00000010000000,
      S_FMUL   = 14'b00000100000000,
      S_FWAIT  = 14'b00001000000000,
      S_FCHK   = 14'b00010000000000,
      S_FDIV   = 14'b00100000000000,
      S_DWAIT  = 14'b01000000000000,
      S_OUT    = 14'b10000000000000
   } state_type;

   state_type    state_ff, state_in;
   fit_step_type step_ff, step_in;
   div_sel_type  sel_ff, sel_in;
   logic         valid_ff, valid_in;

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      sel_in     = sel_ff;
      valid_in   = valid_ff & ~rsp_tready;
      req_tready = 1'b0;
      acmd.op    = A_NONE;
      scmd       = '0;
      scmd.step    = step_ff;
      scmd.div_sel = sel_ff;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               acmd.op = A_LOAD;
               step_in = STEP_WSXX;
               if (astat.room) begin
                  state_in = S_PROJ1;
               end else if (req_tlast) begin
                  state_in = S_FMUL;
               end
            end
         end
         S_PROJ1: begin
            acmd.op  = A_PROJ1;
            state_in = S_PROJ2;
         end
         S_PROJ2: begin
            acmd.op  = A_PROJ2;
            state_in = S_TIME;
         end
         S_TIME: begin
            acmd.op  = A_TIME;
            state_in = S_WEIGHT;
         end
         S_WEIGHT: begin
            acmd.op  = A_WEIGHT;
            state_in = S_WX;
         end
         S_WX: begin
            acmd.op  = A_WX;
            state_in = S_WXT;
         end
         S_WXT: begin
            acmd.op  = A_WXT;
            state_in = S_WXX;
         end
         S_WXX: begin
            acmd.op  = A_WXX;
            state_in = astat.last ? S_FMUL : S_IDLE;
         end
         S_FMUL: begin
            scmd.mul_start = 1'b1;
            state_in       = S_FWAIT;
         end
         S_FWAIT: begin
            if (sstat.mul_done) begin
               scmd.mul_store = 1'b1;
               case (step_ff)
                  STEP_WSXX: begin
                     step_in  = STEP_SXSX;
                     state_in = S_FMUL;
                  end
                  STEP_SXSX: state_in = S_FCHK;
                  STEP_WSXT: begin
                     step_in  = STEP_SXST;
                     state_in = S_FMUL;
                  end
                  STEP_SXST: begin
                     step_in  = STEP_STSXX;
                     state_in = S_FMUL;
                  end
                  STEP_STSXX: begin
                     step_in  = STEP_SXSXT;
                     state_in = S_FMUL;
                  end
                  default: begin
                     sel_in   = DIV_SLOPE;
                     state_in = S_FDIV;
                  end
               endcase
            end
         end
         S_FCHK: begin
            if (sstat.degen) begin
               state_in = S_OUT;
            end else begin
               step_in  = STEP_WSXT;
               state_in = S_FMUL;
            end
         end
         S_FDIV: begin
            scmd.div_start = 1'b1;
            state_in       = S_DWAIT;
         end
         S_DWAIT: begin
            if (sstat.div_done) begin
               scmd.div_store = 1'b1;
               if (sel_ff == DIV_SLOPE) begin
                  sel_in   = DIV_INTERCEPT;
                  state_in = S_FDIV;
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_OUT: begin
            // The previous result must have left before this one loads.
            if (!valid_ff || rsp_tready) begin
               scmd.out_load = 1'b1;
               acmd.op       = A_CLEAR;
               valid_in      = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= STEP_WSXX;
         sel_ff   <= DIV_SLOPE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         sel_ff   <= sel_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;

endmodule

`default_nettype wire

[rtl/core/tglf_accum.sv]
// ----------------------------------------------------------------------------
// Timing gradient line fit pixel accumulator
// Projects each pixel on the event axis and updates the weighted sums.
// ----------------------------------------------------------------------------
`default_nettype none

module tglf_accum (
   input  wire                             clock,
   input  wire                             reset,
   input  wire [tglf_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  wire                             req_tlast,
   input  tglf_pkg::accum_cmd_type         acmd,
   output tglf_pkg::accum_stat_type        astat,
   output tglf_pkg::sums_type              sums
);
   import tglf_pkg::*;

   logic signed [15:0] sig_ff, px_ff, py_ff, cx_ff, cy_ff, cos_ff, sin_ff;
   logic        [11:0] t_ff;
   logic               last_ff;
   logic signed [32:0] p1_ff;
   logic signed [19:0] x_ff;
   logic signed [37:0] wx_ff;
   logic signed [58:0] prod_ff;
   sums_type           sums_ff;
   logic [CNT_W-1:0]   count_ff;

   logic signed [16:0] dx, dy, sig_e;
   logic        [16:0] w;
   logic signed [33:0] xs;
   logic signed [37:0] mul_a;
   logic signed [20:0] mul_b;
   logic signed [58:0] mul_p;

   always_comb begin
      dx    = {px_ff[15], px_ff} - {cx_ff[15], cx_ff};
      dy    = {py_ff[15], py_ff} - {cy_ff[15], cy_ff};
      sig_e = {sig_ff[15], sig_ff};
      w     = sig_ff[15] ? 17'(-sig_e) : 17'(sig_e);
      // Round half up, then an arithmetic shift gives the floor.
      xs    = {p1_ff[32], p1_ff} + {prod_ff[32], prod_ff[32:0]} + 34'sd8192;
      mul_a = '0;
      mul_b = '0;
      case (acmd.op)
         A_PROJ1: begin
            mul_a = {{21{dx[16]}}, dx};
            mul_b = {{5{cos_ff[15]}}, cos_ff};
         end
         A_PROJ2: begin
            mul_a = {{21{dy[16]}}, dy};
            mul_b = {{5{sin_ff[15]}}, sin_ff};
         end
         A_TIME: begin
            mul_a = {21'd0, w};
            mul_b = {9'd0, t_ff};
         end
         A_WEIGHT: begin
            mul_a = {21'd0, w};
            mul_b = {x_ff[19], x_ff};
         end
         A_WX: begin
            mul_a = prod_ff[37:0];
            mul_b = {9'd0, t_ff};
         end
         A_WXT: begin
            mul_a = wx_ff;
            mul_b = {x_ff[19], x_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      case (acmd.op)
         A_LOAD: begin
            sig_ff  <= req_tdata[15:0];
            t_ff    <= req_tdata[27:16];
            px_ff   <= req_tdata[43:28];
            py_ff   <= req_tdata[59:44];
            cx_ff   <= req_tdata[75:60];
            cy_ff   <= req_tdata[91:76];
            cos_ff  <= req_tdata[107:92];
            sin_ff  <= req_tdata[123:108];
            last_ff <= req_tlast;
         end
         A_PROJ1:  prod_ff <= mul_p;
         A_PROJ2: begin
            p1_ff   <= prod_ff[32:0];
            prod_ff <= mul_p;
         end
         A_TIME: begin
            x_ff    <= xs[33:14];
            prod_ff <= mul_p;
         end
         A_WEIGHT: prod_ff <= mul_p;
         A_WX: begin
            wx_ff   <= prod_ff[37:0];
            prod_ff <= mul_p;
         end
         A_WXT:    prod_ff <= mul_p;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sums_ff  <= '0;
         count_ff <= '0;
      end else begin
         case (acmd.op)
            A_WEIGHT: begin
               sums_ff.sum_t      <= sums_ff.sum_t + prod_ff[47:0];
               sums_ff.weight_sum <= sums_ff.weight_sum + {31'd0, w};
            end
            A_WX:  sums_ff.sum_x  <= sums_ff.sum_x + {{5{prod_ff[58]}}, prod_ff};
            A_WXT: sums_ff.sum_xt <= sums_ff.sum_xt + {{5{prod_ff[58]}}, prod_ff};
            A_WXX: begin
               sums_ff.sum_xx <= sums_ff.sum_xx + {{5{prod_ff[58]}}, prod_ff};
               count_ff       <= count_ff + 1'b1;
            end
            A_CLEAR: begin
               sums_ff  <= '0;
               count_ff <= '0;
            end
            default: begin
            end
         endcase
      end
   end

   assign astat.last = last_ff;
   assign astat.room = count_ff < CNT_W'(MAX_PIXELS);
   assign sums       = sums_ff;

endmodule

`default_nettype wire

[rtl/core/tglf_solve.sv]
// ----------------------------------------------------------------------------
// Timing gradient line fit solver
// Wide products by 16-bit digits, restoring division and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tglf_solve (
   input  wire                      clock,
   input  wire                      reset,
   input  tglf_pkg::solve_cmd_type  scmd,
   input  tglf_pkg::sums_type       sums,
   output tglf_pkg::solve_stat_type sstat,
   output logic [31:0]              rsp_slope,
   output logic [31:0]              rsp_intercept,
   output logic                     rsp_status
);
   import tglf_pkg::*;

   function automatic logic [31:0] sat_q(input logic [32:0] q, input logic over,
                                         input logic neg);
      logic [32:0] m;
      if (neg) begin
         m = (over || q > 33'h080000000) ? 33'h080000000 : q;
         sat_q = m[31:0] ^ 32'hFFFFFFFF;
         sat_q = sat_q + 32'd1;
      end else begin
         sat_q = (over || q > 33'h07FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
      end
   endfunction

   // Wide multiplier registers.
   logic         mbusy_ff, mdone_ff;
   logic [1:0]   mcnt_ff;
   logic [127:0] macc_ff;
   logic [63:0]  mam_ff, mbm_ff;
   logic         mneg_ff;

   // Divider registers.
   logic              dbusy_ff, ddone_ff;
   logic [DCNT_W-1:0] dcnt_ff;
   logic [127:0]      da_ff, dr_ff;
   logic [32:0]       dq_ff;
   logic              dover_ff, dneg_ff;

   logic [127:0] a_ff, den_ff, ns_ff, ni_ff;
   logic [31:0]  slope_ff, icpt_ff;
   logic [31:0]  out_slope_ff, out_icpt_ff;
   logic         out_status_ff;

   logic [63:0]  mag_x, mag_xt, op_a, op_b;
   logic         neg_x, neg_xt, op_neg;
   logic [79:0]  mpart;
   logic [127:0] prod, num, diff;
   logic [128:0] rs, rdiff;
   logic         ge;
   logic [32:0]  qn;

   always_comb begin
      neg_x  = sums.sum_x[63];
      neg_xt = sums.sum_xt[63];
      mag_x  = neg_x ? (64'd0 - sums.sum_x) : sums.sum_x;
      mag_xt = neg_xt ? (64'd0 - sums.sum_xt) : sums.sum_xt;
      case (scmd.step)
         STEP_WSXX: begin
            op_a = {16'd0, sums.weight_sum};
            op_b = sums.sum_xx;
            op_neg = 1'b0;
         end
         STEP_SXSX: begin
            op_a = mag_x;
            op_b = mag_x;
            op_neg = 1'b0;
         end
         STEP_WSXT: begin
            op_a = {16'd0, sums.weight_sum};
            op_b = mag_xt;
            op_neg = neg_xt;
         end
         STEP_SXST: begin
            op_a = mag_x;
            op_b = {16'd0, sums.sum_t};
            op_neg = neg_x;
         end
         STEP_STSXX: begin
            op_a = {16'd0, sums.sum_t};
            op_b = sums.sum_xx;
            op_neg = 1'b0;
         end
         default: begin
            op_a = mag_x;
            op_b = mag_xt;
            op_neg = neg_x ^ neg_xt;
         end
      endcase
      mpart = 80'(mam_ff) * 80'(mbm_ff[63:48]);
      prod  = mneg_ff ? (128'd0 - macc_ff) : macc_ff;
      diff  = a_ff - prod;
      num   = (scmd.div_sel == DIV_INTERCEPT) ? ni_ff : ns_ff;
      rs    = {dr_ff, da_ff[127]};
      rdiff = rs - {1'b0, den_ff};
      ge    = rs >= {1'b0, den_ff};
      qn    = {dq_ff[31:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mbusy_ff <= 1'b0;
         mdone_ff <= 1'b0;
         mcnt_ff  <= '0;
         dbusy_ff <= 1'b0;
         ddone_ff <= 1'b0;
         dcnt_ff  <= '0;
      end else begin
         if (scmd.mul_start) begin
            mbusy_ff <= 1'b1;
            mdone_ff <= 1'b0;
            mcnt_ff  <= '0;
         end else if (mbusy_ff) begin
            mcnt_ff <= mcnt_ff + 2'd1;
            if (mcnt_ff == 2'd3) begin
               mbusy_ff <= 1'b0;
               mdone_ff <= 1'b1;
            end
         end
         if (scmd.div_start) begin
            dbusy_ff <= 1'b1;
            ddone_ff <= 1'b0;
            dcnt_ff  <= '0;
         end else if (dbusy_ff) begin
            dcnt_ff <= dcnt_ff + 1'b1;
            if (dcnt_ff == DCNT_W'(DIV_STEPS - 1)) begin
               dbusy_ff <= 1'b0;
               ddone_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      // Multiplier: most significant 16-bit digit of the second operand first.
      if (scmd.mul_start) begin
         macc_ff <= '0;
         mam_ff  <= op_a;
         mbm_ff  <= op_b;
         mneg_ff <= op_neg;
      end else if (mbusy_ff) begin
         macc_ff <= {macc_ff[111:0], 16'd0} + {48'd0, mpart};
         mbm_ff  <= {mbm_ff[47:0], 16'd0};
      end
      if (scmd.mul_store) begin
         case (scmd.step)
            STEP_SXSX:  den_ff <= diff;
            STEP_SXST:  ns_ff  <= diff;
            STEP_SXSXT: ni_ff  <= diff;
            default:    a_ff   <= prod;
         endcase
      end
      // Divider: magnitude of the numerator, then twelve zero bits of fraction.
      if (scmd.div_start) begin
         dneg_ff  <= num[127];
         da_ff    <= num[127] ? (128'd0 - num) : num;
         dr_ff    <= '0;
         dq_ff    <= '0;
         dover_ff <= 1'b0;
      end else if (dbusy_ff) begin
         da_ff <= {da_ff[126:0], 1'b0};
         dr_ff <= ge ? rdiff[127:0] : rs[127:0];
         if (!dover_ff) begin
            dq_ff    <= qn;
            dover_ff <= qn[32];
         end
      end
      if (scmd.div_store) begin
         if (scmd.div_sel == DIV_INTERCEPT) begin
            icpt_ff <= sat_q(dq_ff, dover_ff, dneg_ff);
         end else begin
            slope_ff <= sat_q(dq_ff, dover_ff, dneg_ff);
         end
      end
      if (scmd.out_load) begin
         out_slope_ff  <= sstat.degen ? 32'd0 : slope_ff;
         out_icpt_ff   <= sstat.degen ? 32'd0 : icpt_ff;
         out_status_ff <= sstat.degen;
      end
   end

   assign sstat.mul_done = mdone_ff;
   assign sstat.div_done = ddone_ff;
   assign sstat.degen    = (sums.weight_sum == 48'd0) || den_ff[127] || (den_ff == 128'd0);
   assign rsp_slope      = out_slope_ff;
   assign rsp_intercept  = out_icpt_ff;
   assign rsp_status     = out_status_ff;

endmodule

`default_nettype wire

[rtl/core/timing_gradient_line_fit_top.sv]
// ----------------------------------------------------------------------------
// Timing gradient line fit
// Weighted least-squares fit of pixel peak time along the event axis.
// ----------------------------------------------------------------------------
// Each transaction on the request side is one pixel; tlast closes the event.
// A pixel steps through the PROJ1 to WXX states, set by the single shared
// projection and weight multiplier that its six products pass through in turn;
// the next pixel waits for them. Closing an event runs six 128-bit products on
// the 64x16 digit multiplier, then two 140-step restoring divisions for slope
// and intercept; a degenerate fit stops after two products. One result per
// event waits in the output register while the next event's pixels are taken.
`default_nettype none

`include "timing_gradient_line_fit_top_assert.svh"

module timing_gradient_line_fit_top (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // signal, peak_time, pixel_x, pixel_y, center_x, center_y, cos_psi, sin_psi
   input  wire [tglf_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire                                req_tlast,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // slope, intercept
   output logic [tglf_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // status
   output logic [0:0]                         rsp_tuser
);
   import tglf_pkg::*;

   accum_cmd_type  acmd;
   accum_stat_type astat;
   solve_cmd_type  scmd;
   solve_stat_type sstat;
   sums_type       sums;
   logic [31:0]    slope, intercept;
   logic           status;

   tglf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .acmd       (acmd),
      .astat      (astat),
      .scmd       (scmd),
      .sstat      (sstat)
   );

   tglf_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .acmd      (acmd),
      .astat     (astat),
      .sums      (sums)
   );

   tglf_solve u_solve (
      .clock         (clock),
      .reset         (reset),
      .scmd          (scmd),
      .sums          (sums),
      .sstat         (sstat),
      .rsp_slope     (slope),
      .rsp_intercept (intercept),
      .rsp_status    (status)
   );

   assign rsp_tdata = {intercept, slope};
   assign rsp_tuser = status;

   `TGLF_ASSERT_SAME(a_degen_zero, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata == 64'd0, "degenerate result carries nonzero data")
   `TGLF_ASSERT_NEXT(a_last_busy, clock, reset, req_tvalid && req_tready && req_tlast, !req_tready, "block ready right after the last pixel of an event")

endmodule

`default_nettype wire

[sim/timing_gradient_line_fit_top_tb.sv]
// ----------------------------------------------------------------------------
// Timing gradient line fit testbench
// Streams camera events pixel by pixel, predicts each fitted line from the
// accumulated weighted sums, and compares every result field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module timing_gradient_line_fit_top_tb;
   import tglf_pkg::*;

   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 600;
   localparam int RANDOM_PIXELS = 1000;

   typedef struct packed {
      logic        last;
      logic [15:0] sin_psi;
      logic [15:0] cos_psi;
      logic [15:0] center_y;
      logic [15:0] center_x;
      logic [15:0] pixel_y;
      logic [15:0] pixel_x;
      logic [11:0] peak_time;
      logic [15:0] signal;
   } pixel_type;

   localparam int PIX_W = $bits(pixel_type);

   typedef struct packed {
      logic [31:0] slope;
      logic [31:0] intercept;
      logic        status;
   } fit_type;

   typedef struct {
      pixel_type pix;
      logic      check_fixed;
      fit_type   fixed_fit;
   } stim_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;

   timing_gradient_line_fit_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // Predictor state: the running sums of the current event.
   logic [47:0] fit_w;
   logic [63:0] fit_sx;
   logic [47:0] fit_st;
   logic [63:0] fit_sxt;
   logic [63:0] fit_sxx;
   int          fit_pixels;

   fit_type     pending_fits[$];
   logic        pending_fixed[$];
   fit_type     pending_fixed_fits[$];
   int          errors = 0;
   int          idle_cycles = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   bit          recv_hold = 1'b0;

   function automatic logic [31:0] fit_divide(logic signed [127:0] num,
                                              logic signed [127:0] den);
      logic signed [141:0] q;
      q = ($signed({num, 12'b0}) / $signed({14'b0, den}));
      if (q > 142'sd2147483647) return 32'h7fffffff;
      if (q < -142'sd2147483648) return 32'h80000000;
      return q[31:0];
   endfunction

   // Adds a pixel to the sums while under MAX_PIXELS; returns 1 with the fit when the event closes.
   function automatic bit fit_pixel(pixel_type p, output fit_type f);
      logic signed [63:0]  dx, dy, xq, x;
      logic [63:0]         w, t, wx;
      logic signed [127:0] den, ns, ni, sx, sxt;
      f = '0;
      if (fit_pixels < MAX_PIXELS) begin
         dx = $signed(p.pixel_x) - $signed(p.center_x);
         dy = $signed(p.pixel_y) - $signed(p.center_y);
         xq = dx * $signed(p.cos_psi) + dy * $signed(p.sin_psi) + 64'sd8192;
         x = xq >>> 14;
         w = $signed(p.signal) < 0 ? -64'($signed(p.signal)) : 64'(p.signal);
         t = 64'(p.peak_time);
         wx = x * w;
         fit_w = fit_w + w[47:0];
         fit_st = fit_st + 48'(t * w);
         fit_sx = fit_sx + wx;
         fit_sxt = fit_sxt + wx * t;
         fit_sxx = fit_sxx + wx * x;
         fit_pixels++;
      end
      if (!p.last) return 1'b0;
      sx = $signed(fit_sx);
      sxt = $signed(fit_sxt);
      den = $signed({80'b0, fit_w}) * $signed({64'b0, fit_sxx}) - sx * sx;
      if (fit_w == 0 || den <= 0) begin
         f.status = 1'b1;
      end else begin
         ns = $signed({80'b0, fit_w}) * sxt - sx * $signed({80'b0, fit_st});
         ni = $signed({80'b0, fit_st}) * $signed({64'b0, fit_sxx}) - sx * sxt;
         f.slope = fit_divide(ns, den);
         f.intercept = fit_divide(ni, den);
      end
      fit_w = '0; fit_sx = '0; fit_st = '0; fit_sxt = '0; fit_sxx = '0;
      fit_pixels = 0;
      return 1'b1;
   endfunction

   // Valid stays high from one transaction to the next unless the sender idles.
   task automatic send_pixel(pixel_type p, logic check_fixed, fit_type fixed_fit);
      fit_type f;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata <= {4'b0, p[123:0]};
      req_tlast <= p.last;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (fit_pixel(p, f)) begin
         pending_fits.push_back(f);
         pending_fixed.push_back(check_fixed);
         pending_fixed_fits.push_back(fixed_fit);
      end
      @(negedge clock);
   endtask

   function automatic pixel_type random_pixel(bit last);
      pixel_type p;
      int a;
      p = PIX_W'({$urandom, $urandom, $urandom, $urandom});
      p.peak_time = 12'($urandom);
      // Mostly a realistic camera geometry, half of those with a unit axis vector.
      if ($urandom_range(9) != 0) begin
         p.pixel_x = 16'($signed($urandom_range(2000)) - 1000);
         p.pixel_y = 16'($signed($urandom_range(2000)) - 1000);
         p.center_x = 16'($signed($urandom_range(400)) - 200);
         p.center_y = 16'($signed($urandom_range(400)) - 200);
         a = $urandom_range(3);
         p.cos_psi = (a == 0) ? 16'sd16384 : (a == 1) ? -16'sd11585 : 16'($urandom_range(32767) - 16384);
         p.sin_psi = (a == 0) ? 16'sd0 : (a == 1) ? 16'sd11585 : 16'($urandom_range(32767) - 16384);
      end
      if ($urandom_range(19) == 0) p.signal = 16'h0;
      p.last = last;
      return p;
   endfunction

   task automatic run_events(int pixels);
      int n, k;
      n = 0;
      while (n < pixels) begin
         k = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 12);
         for (int i = 0; i < k; i++) send_pixel(random_pixel(i == k - 1), 1'b0, '0);
         n += k;
      end
   endtask

   task automatic wait_empty();
      req_tvalid <= 1'b0;
      while (pending_fits.size() != 0) @(negedge clock);
   endtask

   // Result checking at the rising edge.
   always @(posedge clock) begin
      fit_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         idle_cycles <= 0;
         got = {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tuser[0]};
         if (pending_fits.size() == 0) begin
            $display("%0t: unexpected result slope=%h intercept=%h status=%b",
                     $time, got.slope, got.intercept, got.status);
            errors++;
         end else begin
            want = pending_fits.pop_front();
            if (pending_fixed.pop_front()) begin
               if (pending_fixed_fits[0] != want) begin
                  $display("%0t: table entry expected %h, predictor gives %h",
                           $time, pending_fixed_fits[0], want);
                  errors++;
               end
            end
            void'(pending_fixed_fits.pop_front());
            if (got.slope !== want.slope) begin
               $display("%0t: slope expected %h actual %h", $time, want.slope, got.slope);
               errors++;
            end
            if (got.intercept !== want.intercept) begin
               $display("%0t: intercept expected %h actual %h",
                        $time, want.intercept, got.intercept);
               errors++;
            end
            if (got.status !== want.status) begin
               $display("%0t: status expected %b actual %b", $time, want.status, got.status);
               errors++;
            end
         end
      end else if (!reset && req_tvalid && req_tready) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Receiver: random stalls plus an optional long hold-off.
   always @(negedge clock) begin
      rsp_tready <= !reset && !recv_hold && ($urandom_range(99) >= recv_stall_pct);
   end

   initial begin
      stim_row_type rows[$];
      stim_row_type r;
      pixel_type    p;

      fit_w = '0; fit_sx = '0; fit_st = '0; fit_sxt = '0; fit_sxx = '0;
      fit_pixels = 0;

      // Directed table: a lone pixel gives a degenerate fit (zero spread).
      p = '0; p.signal = 16'h7fff; p.peak_time = 12'hfff; p.last = 1'b1;
      r.pix = p; r.check_fixed = 1'b1; r.fixed_fit = '{32'h0, 32'h0, 1'b1};
      rows.push_back(r);
      // Zero weight event.
      p = '0; p.pixel_x = 16'h7fff; p.cos_psi = 16'sd16384; p.last = 1'b1;
      r.pix = p; rows.push_back(r);
      // Two pixels on a line t = 16*x: x = 0, t = 0 and x = 1, t = 16.
      p = '0; p.signal = 16'sd100; p.cos_psi = 16'sd16384;
      r.pix = p; r.check_fixed = 1'b0; r.fixed_fit = '0; rows.push_back(r);
      p.pixel_x = 16'sd1; p.peak_time = 12'd16; p.signal = 16'h8000; p.last = 1'b1;
      r.pix = p; r.check_fixed = 1'b1;
      r.fixed_fit = '{32'h0001_0000, 32'h0, 1'b0}; rows.push_back(r);
      // Extremes of position and angle, including the out-of-range -32768.
      p = '0; p.signal = 16'h8000; p.peak_time = 12'hfff; p.pixel_x = 16'h7fff;
      p.pixel_y = 16'h8000; p.center_x = 16'h8000; p.center_y = 16'h7fff;
      p.cos_psi = 16'h8000; p.sin_psi = 16'h8000;
      r.pix = p; r.check_fixed = 1'b0; rows.push_back(r);
      p.pixel_x = 16'h8000; p.pixel_y = 16'h7fff; p.cos_psi = 16'sd16384;
      p.sin_psi = -16'sd16384; p.peak_time = 12'h0;
      r.pix = p; rows.push_back(r);
      p.signal = 16'sd1; p.pixel_x = 16'h0; p.pixel_y = 16'h0; p.peak_time = 12'h800;
      p.last = 1'b1; r.pix = p; rows.push_back(r);
      // Rounding half up at the projection.
      p = '0; p.signal = 16'sd7; p.pixel_x = 16'sd1; p.cos_psi = 16'sd8192;
      p.peak_time = 12'd5; r.pix = p; rows.push_back(r);
      p.pixel_x = -16'sd1; p.peak_time = 12'd50; r.pix = p; rows.push_back(r);
      p.pixel_x = 16'sd3; p.sin_psi = -16'sd1; p.last = 1'b1; r.pix = p; rows.push_back(r);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) send_pixel(rows[i].pix, rows[i].check_fixed, rows[i].fixed_fit);

      // An event past the pixel limit, closed by a pixel that is not summed.
      for (int i = 0; i <= MAX_PIXELS; i++) begin
         p = random_pixel(i == MAX_PIXELS);
         send_pixel(p, 1'b0, '0);
      end
      wait_empty();

      // Long receiver hold-off while events keep coming.
      recv_hold = 1'b1;
      fork
         begin
            repeat (3000) @(negedge clock);
            recv_hold = 1'b0;
         end
         run_events(40);
      join
      wait_empty();

      run_events(RANDOM_PIXELS / 4);
      send_idle_pct = 59;
      run_events(RANDOM_PIXELS / 4);
      send_idle_pct = 0; recv_stall_pct = 59;
      run_events(RANDOM_PIXELS / 4);
      send_idle_pct = 11; recv_stall_pct = 11;
      run_events(RANDOM_PIXELS / 4);

      wait_empty();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (errors == 0 && pending_fits.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
